@@ src/crs_pkg.sv @@
// shared types, constants and helpers for the column representative selector
`timescale 1ns / 1ps
package crs_pkg;
  localparam int MAX_LETTERS = 256;
  localparam int MAX_COLUMNS = 64;
  localparam int COL_W = 6;
  localparam int TAG_W = 16;
  localparam int SCORE_W = 32;
  localparam int FRAC_W = 17;
  localparam int CNT_W = $clog2(MAX_LETTERS + 1);
  localparam int STEP_W = $clog2(MAX_LETTERS);
  localparam int POS_W = CNT_W + 1;
  localparam int PROD_W = CNT_W + FRAC_W;

  localparam logic [FRAC_W-1:0] FULL_FRACTION = FRAC_W'(65536);

  localparam logic [1:0] ST_REP = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_ERR = 2'd2;

  localparam logic [2:0] REG_PERCENT_MODE = 3'd0;
  localparam logic [2:0] REG_PICK_HIGHEST = 3'd1;
  localparam logic [2:0] REG_USE_MEDIAN = 3'd2;
  localparam logic [2:0] REG_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_KEEP_FRACTION = 3'd4;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [COL_W-1:0] column;
    logic [TAG_W-1:0] tag;
  } letter_t;

  function automatic logic beats(input logic hi, input logic signed [SCORE_W-1:0] a,
                                 input logic signed [SCORE_W-1:0] b);
    beats = hi ? (a > b) : (a < b);
  endfunction
endpackage

@@ src/crs_cell.sv @@
// one storage cell of the letter chain
`timescale 1ns / 1ps
module crs_cell (
  input  logic            clk,
  input  logic            shift,
  input  crs_pkg::letter_t d,
  output crs_pkg::letter_t q
);
  import crs_pkg::*;

  letter_t held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= d;
    end
  end

  assign q = held;
endmodule

@@ src/column_representative_selector.sv @@
// top level: letter chain, column scan sequencer and result register
// each column needs one chain rotation, two if ranked in percentage mode (when the column
//   has a candidate); the sequencer gives one result word per column
// throughput: one letter per cycle while loading; in_stall holds off new letters while the
//   columns are scanned and while a result word waits under out_stall
// reset: synchronous, clears the letter count, the sequencer and the registers to defaults
`timescale 1ns / 1ps
module column_representative_selector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [crs_pkg::COL_W-1:0]     letter_column,
  input  logic [crs_pkg::TAG_W-1:0]     letter_tag,
  input  logic signed [crs_pkg::SCORE_W-1:0] mean_value,
  input  logic signed [crs_pkg::SCORE_W-1:0] median_value,
  input  logic                          last_letter,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [crs_pkg::COL_W-1:0]     out_column,
  output logic [crs_pkg::TAG_W-1:0]     out_tag,
  output logic signed [crs_pkg::SCORE_W-1:0] out_score,
  output logic [1:0]                    status,
  output logic                          end_of_run
);
  import crs_pkg::*;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_RANK = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_ERR = 3'd4;

  logic percent_mode, pick_highest, use_median_score;
  logic signed [SCORE_W-1:0] score_threshold;
  logic [FRAC_W-1:0] keep_fraction;

  logic [2:0] state;
  logic [CNT_W-1:0] letter_count;
  logic [STEP_W-1:0] step;
  logic [COL_W-1:0] col_idx;
  logic found, chosen;
  logic signed [SCORE_W-1:0] best_score;
  logic [TAG_W-1:0] best_tag;
  logic [STEP_W-1:0] best_idx;
  logic [CNT_W-1:0] rank;

  letter_t chain [MAX_LETTERS];
  letter_t head, feed, incoming;
  logic shift;

  logic load_acc, store_it;
  logic [POS_W-1:0] pos, idx_full;
  logic [STEP_W-1:0] idx;
  logic live, past, take, rank_hit, last_step;
  logic found_next;
  logic [CNT_W-1:0] rank_next;
  logic [FRAC_W-1:0] frac_sat;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-17:0] kval_raw;
  logic [PROD_W-17:0] kval;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      percent_mode <= 1'b0;
      pick_highest <= 1'b1;
      use_median_score <= 1'b0;
      score_threshold <= '0;
      keep_fraction <= FULL_FRACTION;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PERCENT_MODE:  percent_mode <= cfg_data[0];
        REG_PICK_HIGHEST:  pick_highest <= cfg_data[0];
        REG_USE_MEDIAN:    use_median_score <= cfg_data[0];
        REG_THRESHOLD:     score_threshold <= cfg_data;
        REG_KEEP_FRACTION: keep_fraction <= cfg_data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // letter chain
  assign head = chain[MAX_LETTERS-1];
  assign incoming.score = use_median_score ? median_value : mean_value;
  assign incoming.column = letter_column;
  assign incoming.tag = letter_tag;
  assign load_acc = in_valid && !in_stall;
  assign store_it = load_acc && (letter_column < MAX_COLUMNS) &&
                    (letter_count < CNT_W'(MAX_LETTERS));
  assign shift = store_it || state == S_FIND || state == S_RANK;
  assign feed = store_it ? incoming : head;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_LETTERS; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        crs_cell u_cell (.clk(clk), .shift(shift), .d(feed), .q(chain[gi]));
      end else begin : g_rest
        crs_cell u_cell (.clk(clk), .shift(shift), .d(chain[gi-1]), .q(chain[gi]));
      end
    end
  endgenerate

  // scan of the head cell
  always_comb begin
    pos = POS_W'(step) + POS_W'(letter_count);
    live = pos >= POS_W'(MAX_LETTERS);
    idx_full = pos - POS_W'(MAX_LETTERS);
    idx = idx_full[STEP_W-1:0];
    past = pick_highest ? (head.score > score_threshold) : (head.score < score_threshold);
    take = live && head.column == col_idx && (percent_mode || past) &&
           (!found || beats(pick_highest, head.score, best_score));
    found_next = found || take;
    rank_hit = live && (beats(pick_highest, head.score, best_score) ||
               (head.score == best_score && idx < best_idx));
    rank_next = rank_hit ? rank + CNT_W'(1) : rank;
    last_step = step == STEP_W'(MAX_LETTERS - 1);
    frac_sat = (keep_fraction > FULL_FRACTION) ? FULL_FRACTION : keep_fraction;
    prod = PROD_W'(letter_count) * PROD_W'(frac_sat);
    kval_raw = prod[PROD_W-1:16];
    kval = (kval_raw == '0) ? (PROD_W-16)'(1) : kval_raw;
  end

  always_ff @(posedge clk) begin
    if (state == S_FIND && take) begin
      best_score <= head.score;
      best_tag <= head.tag;
      best_idx <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      letter_count <= '0;
      step <= '0;
      col_idx <= '0;
      found <= 1'b0;
      chosen <= 1'b0;
      rank <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (store_it) letter_count <= letter_count + CNT_W'(1);
          if (load_acc && last_letter) begin
            step <= '0;
            col_idx <= '0;
            found <= 1'b0;
            if (percent_mode && letter_count == '0 && !store_it) state <= S_ERR;
            else state <= S_FIND;
          end
        end
        S_FIND: begin
          found <= found_next;
          step <= step + STEP_W'(1);
          if (last_step) begin
            if (percent_mode && found_next) begin
              state <= S_RANK;
              rank <= '0;
            end else begin
              state <= S_EMIT;
              chosen <= found_next;
            end
          end
        end
        S_RANK: begin
          rank <= rank_next;
          step <= step + STEP_W'(1);
          if (last_step) begin
            state <= S_EMIT;
            chosen <= (PROD_W-16)'(rank_next) < kval;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            found <= 1'b0;
            if (col_idx == COL_W'(MAX_COLUMNS - 1)) begin
              state <= S_LOAD;
              letter_count <= '0;
            end else begin
              col_idx <= col_idx + COL_W'(1);
              state <= S_FIND;
            end
          end
        end
        S_ERR: begin
          if (!out_stall) begin
            state <= S_LOAD;
            letter_count <= '0;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign in_stall = state != S_LOAD;
  assign out_valid = state == S_EMIT || state == S_ERR;
  assign out_column = (state == S_ERR) ? '0 : col_idx;
  assign out_tag = (state == S_EMIT && chosen) ? best_tag : '0;
  assign out_score = (state == S_EMIT && chosen) ? best_score : '0;
  assign status = (state == S_ERR) ? ST_ERR : (chosen ? ST_REP : ST_NONE);
  assign end_of_run = (state == S_ERR) || col_idx == COL_W'(MAX_COLUMNS - 1);

  a_no_load_during_output: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("letter accepted while a result is pending");
  a_error_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_ERR) |-> end_of_run) else $error("error word without end");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    letter_count <= CNT_W'(MAX_LETTERS)) else $error("letter count overflow");
  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_run && !out_stall) |=> (letter_count == '0 && !out_valid))
    else $error("run not cleared after last word");
endmodule
